// ===== rtl/core/mwws_pkg.sv =====
// Shared types and constants of the multi-watch watchdog supervisor.
package mwws_pkg;

   localparam int MaxWatchesDef = 8;
   localparam int CheckBits     = 8;
   localparam int NoFail        = 8;
   localparam int OutIdxW       = 4;
   localparam int TimeW         = 32;
   localparam int CsrIdxW       = 2;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TIME_SOURCE = 2'd0,
      CSR_RESET       = 2'd1,
      CSR_FEED        = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_FEED = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 cmd;
      logic [TimeW-1:0]     watch_tmo;
      logic [CheckBits-1:0] check_results;
      logic [TimeW-1:0]     now_ms;
   } req_type;

   typedef struct packed {
      logic               feed_pulse;
      logic               reset_request;
      logic [OutIdxW-1:0] failing_watch;
      logic               add_accepted;
      logic [OutIdxW-1:0] watch_count;
      logic               setup_valid;
   } rsp_type;

   typedef struct packed {
      logic [CsrIdxW-1:0] index;
      logic               data;
   } csr_type;

endpackage

// ===== rtl/core/mwws_chan_if.sv =====
// Valid/ready channel carrying one payload of a given type.
interface mwws_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/multi_watch_watchdog_supervisor_unit.sv =====
// Supervisor over a table of watched tasks: add watches, walk them on a feed request.
//
// Each request on req_chan either appends a watch (cmd add) or runs a feed check
// (cmd feed), and gives exactly one response on rsp_chan. Timeouts and stamps live
// in two synchronous memories of MAX_WATCHES words each, with one read and one
// write port; a feed walks the registered watches in slot order, reading one slot
// per cycle and writing back refreshed stamps behind the read. A finished response
// waits in the output register while the next request is accepted. The tables need
// no clearing pass: only slots below the watch count are ever read. Configuration
// writes on csr_chan are always taken and must be made while the block is idle.
module multi_watch_watchdog_supervisor_unit
   import mwws_pkg::*;
#(
   parameter int MAX_WATCHES = MaxWatchesDef
) (
   input  logic         clock,
   input  logic         reset,
   mwws_chan_if.sink    req_chan,
   mwws_chan_if.source  rsp_chan,
   mwws_chan_if.sink    csr_chan
);

   localparam int IdxW = (MAX_WATCHES > 1) ? $clog2(MAX_WATCHES) : 1;
   localparam int CntW = $clog2(MAX_WATCHES + 1);
   localparam int ChkW = $clog2(CheckBits);

   // Configuration registers
   logic ts_en_ff, ts_en_in;
   logic rst_en_ff, rst_en_in;
   logic feed_en_ff, feed_en_in;

   // Control state
   state_type       state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   req_type         req_ff, req_in;

   // Walk pipeline: issue side and evaluate side
   logic [IdxW-1:0] issue_idx_ff, issue_idx_in;
   logic            issue_more_ff, issue_more_in;
   logic            data_vld_ff, data_vld_in;
   logic [IdxW-1:0] data_idx_ff, data_idx_in;

   // Memories and their registered read data
   logic [TimeW-1:0] tmo_mem [MAX_WATCHES];
   logic [TimeW-1:0] stp_mem [MAX_WATCHES];
   logic [TimeW-1:0] tmo_rd_ff;
   logic [TimeW-1:0] stp_rd_ff;

   // Pending and presented response
   rsp_type res_ff, res_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff, rsp_vld_in;

   // Decoded controls
   logic             req_acc;
   logic             rsp_free;
   logic             has_room;
   logic [IdxW-1:0]  slot;
   logic             setup_ok;
   logic             req_rdy;
   logic             rd_en;
   logic             tmo_we;
   logic             stp_we;
   logic [IdxW-1:0]  stp_wa;
   logic [TimeW-1:0] stp_wd;
   logic             load_rsp;

   // Evaluation of the watch whose data has just been read
   logic [ChkW-1:0]  chk_pos;
   logic [31:0]      idx_wide;
   logic             chk_pass;
   logic [TimeW-1:0] elapsed;
   logic             expired;
   logic             stop;
   logic             last;
   logic             walk_done;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_vld_ff || rsp_chan.ready;
   assign has_room = count_ff < CntW'(MAX_WATCHES);
   assign slot     = IdxW'(count_ff);
   assign setup_ok = feed_en_ff || (rst_en_ff && ts_en_ff);

   // Watches beyond the check bits carry no result and count as passing.
   assign chk_pos   = ChkW'(data_idx_ff);
   assign idx_wide  = 32'(data_idx_ff);
   assign chk_pass  = (idx_wide >= 32'(CheckBits)) || req_ff.check_results[chk_pos];
   // Elapsed time wraps modulo 2^32.
   assign elapsed   = req_ff.now_ms - stp_rd_ff;
   assign expired   = tmo_rd_ff < elapsed;
   // Without a time source any failure stops the walk.
   assign stop      = data_vld_ff && !chk_pass && (!ts_en_ff || expired);
   assign last      = data_vld_ff && ((CntW'(data_idx_ff) + CntW'(1)) == count_ff);
   assign walk_done = stop || last;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.payload.cmd == CMD_ADD) begin
                  state_in = ST_ADD;
               end else if (count_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_ADD: begin
            state_in = ST_FINISH;
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs: handshake, memory strobes, response load
   always_comb begin
      req_rdy  = 1'b0;
      rd_en    = 1'b0;
      tmo_we   = 1'b0;
      stp_we   = 1'b0;
      stp_wa   = data_idx_ff;
      stp_wd   = req_ff.now_ms;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_rdy = 1'b1;
         end
         ST_ADD: begin
            // Stamp a new watch with zero when there is no time source.
            tmo_we = has_room;
            stp_we = has_room;
            stp_wa = slot;
            stp_wd = ts_en_ff ? req_ff.now_ms : '0;
         end
         ST_WALK: begin
            rd_en  = issue_more_ff;
            // Refresh a passing watch behind the read of the next slot.
            stp_we = data_vld_ff && chk_pass && ts_en_ff;
         end
         ST_FINISH: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_rdy = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = req_rdy;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

   // Register next values
   always_comb begin
      ts_en_in      = ts_en_ff;
      rst_en_in     = rst_en_ff;
      feed_en_in    = feed_en_ff;
      count_in      = count_ff;
      req_in        = req_ff;
      issue_idx_in  = issue_idx_ff;
      issue_more_in = issue_more_ff;
      data_vld_in   = 1'b0;
      data_idx_in   = data_idx_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_vld_in    = rsp_vld_ff;

      if (csr_chan.valid) begin
         if (csr_chan.payload.index == CSR_TIME_SOURCE) begin
            ts_en_in = csr_chan.payload.data;
         end
         if (csr_chan.payload.index == CSR_RESET) begin
            rst_en_in = csr_chan.payload.data;
         end
         if (csr_chan.payload.index == CSR_FEED) begin
            feed_en_in = csr_chan.payload.data;
         end
      end

      if (req_acc) begin
         req_in        = req_chan.payload;
         issue_idx_in  = '0;
         issue_more_in = 1'b1;
         // Preset a completed walk; a stopping watch overrides it.
         res_in.feed_pulse    = feed_en_ff;
         res_in.reset_request = 1'b0;
         res_in.failing_watch = OutIdxW'(NoFail);
         res_in.add_accepted  = 1'b0;
         res_in.watch_count   = OutIdxW'(count_ff);
         res_in.setup_valid   = setup_ok;
      end

      if (state_ff == ST_ADD) begin
         res_in.feed_pulse    = 1'b0;
         res_in.reset_request = 1'b0;
         res_in.failing_watch = OutIdxW'(NoFail);
         res_in.add_accepted  = has_room;
         if (has_room) begin
            count_in           = count_ff + CntW'(1);
            res_in.watch_count = OutIdxW'(count_ff + CntW'(1));
         end else begin
            res_in.watch_count = OutIdxW'(count_ff);
         end
      end

      if (state_ff == ST_WALK) begin
         // Advance the issue side until the last registered slot is read.
         if (rd_en) begin
            data_idx_in = issue_idx_ff;
            data_vld_in = !walk_done;
            if ((CntW'(issue_idx_ff) + CntW'(1)) == count_ff) begin
               issue_more_in = 1'b0;
            end else begin
               issue_idx_in = issue_idx_ff + IdxW'(1);
            end
         end
         if (stop) begin
            res_in.feed_pulse    = 1'b0;
            res_in.reset_request = rst_en_ff && ts_en_ff;
            res_in.failing_watch = OutIdxW'(data_idx_ff);
         end
      end

      // Hold the response until taken; load the pending one when free.
      if (load_rsp) begin
         rsp_in     = res_ff;
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ts_en_ff      <= 1'b0;
         rst_en_ff     <= 1'b0;
         feed_en_ff    <= 1'b0;
         count_ff      <= '0;
         issue_more_ff <= 1'b0;
         data_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ts_en_ff      <= ts_en_in;
         rst_en_ff     <= rst_en_in;
         feed_en_ff    <= feed_en_in;
         count_ff      <= count_in;
         issue_more_ff <= issue_more_in;
         data_vld_ff   <= data_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      issue_idx_ff <= issue_idx_in;
      data_idx_ff  <= data_idx_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   // Timeout memory: written on add, read during the walk
   always_ff @(posedge clock) begin
      if (tmo_we) begin
         tmo_mem[slot] <= req_ff.watch_tmo;
      end
      if (rd_en) begin
         tmo_rd_ff <= tmo_mem[issue_idx_ff];
      end
   end

   // Stamp memory: written on add and on refresh, read during the walk
   always_ff @(posedge clock) begin
      if (stp_we) begin
         stp_mem[stp_wa] <= stp_wd;
      end
      if (rd_en) begin
         stp_rd_ff <= stp_mem[issue_idx_ff];
      end
   end

endmodule
